FILE: design/iff_pkg.sv
// ----------------------------------------------------------------------------
// iff_pkg
// types and constants shared by the integer field formatter
// ----------------------------------------------------------------------------
package iff_pkg;

    localparam logic [1:0] OP_SDEC = 2'd0;
    localparam logic [1:0] OP_UDEC = 2'd1;
    localparam logic [1:0] OP_HEX  = 2'd2;
    localparam logic [1:0] OP_OCT  = 2'd3;

    localparam logic [6:0] LIMIT_99 = 7'd99;

    // reciprocal of ten, scaled by 2^67
    localparam logic [63:0] RECIP_10 = 64'hCCCC_CCCC_CCCC_CCCD;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  opcode;
        logic        uppercase;
        logic        left_justify;
        logic        plus_sign;
        logic        space_sign;
        logic        zero_pad;
        logic        alternate;
        logic [6:0]  field_width;
        logic        has_precision;
        logic [6:0]  precision;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] text_bytes;
        logic [3:0]  byte_count;
        logic        last;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SETUP,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    // one digit character from a 4-bit digit value
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
        logic [7:0] c;
        begin
            if (d < 4'd10)
                c = 8'h30 + {4'd0, d};
            else if (up)
                c = 8'h37 + {4'd0, d};
            else
                c = 8'h57 + {4'd0, d};
            return c;
        end
    endfunction

endpackage

FILE: design/integer_field_formatter_unit.sv
// ----------------------------------------------------------------------------
// integer_field_formatter_unit
// printf-style integer conversion of a 64-bit value, streamed as text beats
// ----------------------------------------------------------------------------
// An input beat (in_data, in_valid, in_stall) carries the value and the spec.
// The block takes one item at a time: in_stall is high from acceptance until
// the sequencer is back in idle after the last output beat has been taken.
// Digits are produced by one shared unit: a decimal digit takes four 32x32
// partial products of a multiply by the reciprocal of ten, then the digit;
// a hex or octal digit is taken from the low bits; a final pass of ST_CONV
// ends the conversion and ST_SETUP sets up the field.
// Text is then assembled one character per cycle, while there is room, into
// an 8-byte register; each full or final beat then moves to the output register
// (out_data, out_valid, out_stall) once that register is free.
// A field holds at most 101 characters in 13 beats; a decimal value has at
// most 20 digits.
// An empty field gives one beat with byte_count 0 and last set.
// When the receiver stalls, the output beat is held and assembly stops once
// the next beat is full. Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module integer_field_formatter_unit #(
    parameter int BYTES_PER_BEAT = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  iff_pkg::in_beat_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output iff_pkg::out_beat_t  out_data
);

    localparam int CW = $clog2(BYTES_PER_BEAT + 1);

    iff_pkg::state_t state_reg, state_next;

    logic [63:0]  val_reg, val_next;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   ph_reg, ph_next;
    logic [7:0]  dig_reg [0:22];
    logic [4:0]  nd_reg, nd_next;
    logic [1:0]  op_reg;
    logic        up_reg, left_reg, zpad_reg, alt_reg, hasp_reg, neg_reg, plus_reg, space_reg;
    logic [6:0]  width_reg, prec_reg;

    logic [7:0]  sign_reg;
    logic        hexpfx_reg;
    logic [6:0]  lead_reg, zpre_reg, zpad_n_reg;
    logic [6:0]  pos_reg, pos_next;
    logic [6:0]  len_reg;

    logic [63:0] asm_reg, asm_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic        ovalid_reg, ovalid_next;
    iff_pkg::out_beat_t odata_reg, odata_next;

    logic        dig_we;
    logic [7:0]  dig_wd;

    // shared multiplier for the divide by ten
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  prod;
    logic [127:0] prod_sh;
    logic [63:0]  quot;
    logic [3:0]   rem10;
    always_comb
    begin
        mul_a = ph_reg[1] ? val_reg[63:32] : val_reg[31:0];
        mul_b = ph_reg[0] ? iff_pkg::RECIP_10[63:32] : iff_pkg::RECIP_10[31:0];
        prod  = mul_a * mul_b;
        case (ph_reg)
            3'd0:    prod_sh = {64'd0, prod};
            3'd1:    prod_sh = {32'd0, prod, 32'd0};
            3'd2:    prod_sh = {32'd0, prod, 32'd0};
            default: prod_sh = {prod, 64'd0};
        endcase
        quot  = {3'd0, acc_reg[127:67]};
        rem10 = val_reg[3:0] - {acc_reg[67], 3'b000} - {acc_reg[69:67], 1'b0};
    end

    // setup arithmetic
    logic [6:0]  w_sat, p_sat, tprec, pprec, padn, plen;
    logic        has_sign;
    assign w_sat   = (width_reg > iff_pkg::LIMIT_99) ? iff_pkg::LIMIT_99 : width_reg;
    assign p_sat   = (prec_reg > iff_pkg::LIMIT_99) ? iff_pkg::LIMIT_99 : prec_reg;
    assign has_sign = (op_reg == iff_pkg::OP_SDEC) && (neg_reg || plus_reg || space_reg);
    assign plen    = has_sign ? 7'd1 :
                     ((op_reg == iff_pkg::OP_HEX) && alt_reg && (nd_reg != 5'd0)
                      && !(nd_reg == 5'd1 && dig_reg[0] == 8'h30 && val_reg == 64'd0))
                     ? 7'd2 : 7'd0;
    assign tprec   = (hasp_reg && p_sat > {2'd0, nd_reg}) ? p_sat : {2'd0, nd_reg};
    assign pprec   = tprec + plen;
    assign padn    = (w_sat > pprec) ? (w_sat - pprec) : 7'd0;

    // character at current position
    logic [7:0] ch;
    logic [6:0] p, b1, b2, b3, b4, b5;
    always_comb
    begin
        p  = pos_reg;
        b1 = lead_reg;
        b2 = b1 + ((sign_reg != 8'd0) ? 7'd1 : 7'd0) + (hexpfx_reg ? 7'd2 : 7'd0);
        b3 = b2 + zpad_n_reg;
        b4 = b3 + zpre_reg;
        b5 = b4 + {2'd0, nd_reg};
        ch = 8'h20;
        if (p < b1)
            ch = 8'h20;
        else if (sign_reg != 8'd0 && p == b1)
            ch = sign_reg;
        else if (hexpfx_reg && p == b1)
            ch = 8'h30;
        else if (hexpfx_reg && p == b1 + 7'd1)
            ch = up_reg ? 8'h58 : 8'h78;
        else if (p < b4)
            ch = 8'h30;
        else if (p < b5)
            ch = dig_reg[5'(b5 - p - 7'd1)];
        else
            ch = 8'h20;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iff_pkg::ST_IDLE:
                if (in_valid)
                    state_next = iff_pkg::ST_CONV;
            iff_pkg::ST_CONV:
                if (val_reg == 64'd0 && ph_reg == 3'd0)
                    state_next = iff_pkg::ST_SETUP;
            iff_pkg::ST_SETUP:
                state_next = iff_pkg::ST_EMIT;
            iff_pkg::ST_EMIT:
                if (len_reg == 7'd0)
                    state_next = iff_pkg::ST_EMPTY;
                else if (pos_reg == len_reg && cnt_reg == '0 && !ovalid_reg)
                    state_next = iff_pkg::ST_IDLE;
            iff_pkg::ST_EMPTY:
                if (!ovalid_reg)
                    state_next = iff_pkg::ST_IDLE;
            default:
                state_next = iff_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        val_next    = val_reg;
        acc_next    = acc_reg;
        ph_next     = ph_reg;
        nd_next     = nd_reg;
        pos_next    = pos_reg;
        asm_next    = asm_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg && out_stall;
        odata_next  = odata_reg;
        dig_we      = 1'b0;
        dig_wd      = 8'd0;
        case (state_reg)
            iff_pkg::ST_IDLE:
            begin
                nd_next  = 5'd0;
                ph_next  = 3'd0;
                acc_next = 128'd0;
                val_next = (in_data.opcode == iff_pkg::OP_SDEC && in_data.value[63])
                           ? (64'd0 - in_data.value) : in_data.value;
            end
            iff_pkg::ST_CONV:
            begin
                if (op_reg inside {iff_pkg::OP_SDEC, iff_pkg::OP_UDEC})
                begin
                    if (ph_reg != 3'd0 || val_reg != 64'd0)
                    begin
                        if (ph_reg == 3'd4)
                        begin
                            dig_we   = 1'b1;
                            dig_wd   = iff_pkg::digit_char(rem10, 1'b0);
                            nd_next  = nd_reg + 5'd1;
                            val_next = quot;
                            acc_next = 128'd0;
                            ph_next  = 3'd0;
                        end
                        else
                        begin
                            acc_next = acc_reg + prod_sh;
                            ph_next  = ph_reg + 3'd1;
                        end
                    end
                end
                else if (val_reg != 64'd0)
                begin
                    dig_we  = 1'b1;
                    nd_next = nd_reg + 5'd1;
                    if (op_reg == iff_pkg::OP_HEX)
                    begin
                        dig_wd   = iff_pkg::digit_char(val_reg[3:0], up_reg);
                        val_next = val_reg >> 4;
                    end
                    else
                    begin
                        dig_wd   = iff_pkg::digit_char({1'b0, val_reg[2:0]}, 1'b0);
                        val_next = val_reg >> 3;
                    end
                end
                if (val_reg == 64'd0 && ph_reg == 3'd0)
                begin
                    // zero value, or octal alternate leading zero
                    if (nd_reg == 5'd0)
                    begin
                        if (!hasp_reg || p_sat != 7'd0
                            || (op_reg == iff_pkg::OP_OCT && alt_reg))
                        begin
                            dig_we  = 1'b1;
                            dig_wd  = 8'h30;
                            nd_next = 5'd1;
                        end
                    end
                    else if (op_reg == iff_pkg::OP_OCT && alt_reg)
                    begin
                        dig_we  = 1'b1;
                        dig_wd  = 8'h30;
                        nd_next = nd_reg + 5'd1;
                    end
                end
            end
            iff_pkg::ST_SETUP:
            begin
                pos_next = 7'd0;
                cnt_next = '0;
                asm_next = 64'd0;
            end
            iff_pkg::ST_EMIT:
            begin
                if (pos_reg != len_reg && cnt_reg != CW'(BYTES_PER_BEAT))
                begin
                    asm_next[8*cnt_reg +: 8] = ch;
                    cnt_next = cnt_reg + CW'(1);
                    pos_next = pos_reg + 7'd1;
                end
                else if (cnt_reg != '0 && !ovalid_next)
                begin
                    ovalid_next           = 1'b1;
                    odata_next.text_bytes = asm_reg;
                    odata_next.byte_count = 4'(cnt_reg);
                    odata_next.last       = (pos_reg == len_reg);
                    asm_next              = 64'd0;
                    cnt_next              = '0;
                end
                if (len_reg == 7'd0 && !ovalid_next)
                begin
                    ovalid_next           = 1'b1;
                    odata_next.text_bytes = 64'd0;
                    odata_next.byte_count = 4'd0;
                    odata_next.last       = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= iff_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        acc_reg   <= acc_next;
        ph_reg    <= ph_next;
        nd_reg    <= nd_next;
        pos_reg   <= pos_next;
        asm_reg   <= asm_next;
        cnt_reg   <= cnt_next;
        odata_reg <= odata_next;
        if (dig_we)
            dig_reg[nd_reg] <= dig_wd;
        if (state_reg == iff_pkg::ST_IDLE)
        begin
            op_reg    <= in_data.opcode;
            up_reg    <= in_data.uppercase;
            left_reg  <= in_data.left_justify;
            plus_reg  <= in_data.plus_sign;
            space_reg <= in_data.space_sign;
            zpad_reg  <= in_data.zero_pad && !in_data.has_precision;
            alt_reg   <= in_data.alternate;
            width_reg <= in_data.field_width;
            hasp_reg  <= in_data.has_precision;
            prec_reg  <= in_data.precision;
            neg_reg   <= in_data.value[63];
        end
        if (state_reg == iff_pkg::ST_SETUP)
        begin
            sign_reg   <= (op_reg != iff_pkg::OP_SDEC) ? 8'd0 :
                          neg_reg ? 8'h2d : plus_reg ? 8'h2b : space_reg ? 8'h20 : 8'd0;
            hexpfx_reg <= (plen == 7'd2);
            lead_reg   <= (!left_reg && !zpad_reg) ? padn : 7'd0;
            zpad_n_reg <= (!left_reg && zpad_reg) ? padn : 7'd0;
            zpre_reg   <= tprec - {2'd0, nd_reg};
            len_reg    <= pprec + padn;
        end
    end

    assign in_stall  = (state_reg != iff_pkg::ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

endmodule
